/* rtl/jbt_pkg.sv */
// Shared types and codes for the JSON byte tokenizer.
// Depends on nothing; each rtl file but jbt_if.sv uses it by scoped names.
package jbt_pkg;

  // Input opcodes.
  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_END     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TEXT = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Token kinds.
  localparam logic [3:0] TK_LBRACE  = 4'd0;
  localparam logic [3:0] TK_RBRACE  = 4'd1;
  localparam logic [3:0] TK_COLON   = 4'd2;
  localparam logic [3:0] TK_COMMA   = 4'd3;
  localparam logic [3:0] TK_LBRACK  = 4'd4;
  localparam logic [3:0] TK_RBRACK  = 4'd5;
  localparam logic [3:0] TK_STRING  = 4'd6;
  localparam logic [3:0] TK_INTEGER = 4'd7;
  localparam logic [3:0] TK_REAL    = 4'd8;
  localparam logic [3:0] TK_TRUE    = 4'd9;
  localparam logic [3:0] TK_FALSE   = 4'd10;
  localparam logic [3:0] TK_NULL    = 4'd11;

  // Error codes.
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_BAD_CHAR    = 4'd1;
  localparam logic [3:0] ERR_BAD_HEX     = 4'd2;
  localparam logic [3:0] ERR_MINUS       = 4'd3;
  localparam logic [3:0] ERR_LEAD_ZERO   = 4'd4;
  localparam logic [3:0] ERR_POINT       = 4'd5;
  localparam logic [3:0] ERR_EXPONENT    = 4'd6;
  localparam logic [3:0] ERR_EXP_SIGN    = 4'd7;
  localparam logic [3:0] ERR_BAD_SLASH   = 4'd8;
  localparam logic [3:0] ERR_BAREWORD    = 4'd9;
  localparam logic [3:0] ERR_END_IN_TOK  = 4'd10;
  localparam logic [3:0] ERR_PRIOR       = 4'd11;

  localparam int unsigned MAX_RESULTS = 3;

  // One result slot without the per-item fields.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text_byte;
    logic [3:0] token_kind;
  } slot_t;

  // Everything one input item produces.
  typedef struct packed {
    slot_t [MAX_RESULTS-1:0] slots;
    logic [1:0]              count;
    logic                    status;
    logic [3:0]              error_code;
  } bundle_t;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text_byte;
    logic [3:0] token_kind;
    logic       status;
    logic [3:0] error_code;
    logic       last;
  } result_t;

endpackage

/* rtl/jbt_if.sv */
// Valid/ready channel interfaces for the tokenizer's input and result streams.
// Depends on nothing; field widths follow the item definitions.
interface jbt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface jbt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] text_byte;
  logic [3:0] token_kind;
  logic       status;
  logic [3:0] error_code;
  logic       last;

  modport source (output valid, output kind, output text_byte, output token_kind,
                  output status, output error_code, output last, input ready);
  modport sink   (input valid, input kind, input text_byte, input token_kind,
                  input status, input error_code, input last, output ready);
endinterface

/* rtl/jbt_lexer.sv */
// Lexer state registers and the next-state logic that turns one input item
// into a bundle of up to three results. Depends on jbt_pkg.
module jbt_lexer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        data_byte_i,
  output jbt_pkg::bundle_t  bundle_o
);

  typedef enum logic [4:0] {
    S_READY, S_STRING, S_ESC, S_U1, S_U2, S_U3, S_U4, S_NEG, S_ZERO, S_INT,
    S_FRAC, S_FRACMORE, S_EXP, S_EXPSIGN, S_EXPMORE, S_SLASH, S_COMMENT,
    S_WORD, S_ERROR
  } state_e;

  typedef struct packed {
    state_e           st;
    logic [15:0]      cp;
    logic [2:0]       wm;
    logic [2:0]       wl;
    logic [3:0]       err;
    jbt_pkg::bundle_t b;
  } lex_t;

  state_e      state_q;
  logic [15:0] cp_q;
  logic [2:0]  wm_q;
  logic [2:0]  wl_q;
  lex_t        lx;

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
  endfunction

  function automatic lex_t push(lex_t x, logic [1:0] kind, logic [7:0] c, logic [3:0] tok);
    if (x.b.count != 2'd3) begin
      x.b.slots[x.b.count].kind       = kind;
      x.b.slots[x.b.count].text_byte  = c;
      x.b.slots[x.b.count].token_kind = tok;
      x.b.count = x.b.count + 2'd1;
    end
    return x;
  endfunction

  function automatic lex_t put_text(lex_t x, logic [7:0] c);
    return push(x, jbt_pkg::KIND_TEXT, c, 4'd0);
  endfunction

  function automatic lex_t put_done(lex_t x, logic [3:0] tok);
    lex_t y;
    y = push(x, jbt_pkg::KIND_DONE, 8'd0, tok);
    y.st = S_READY;
    return y;
  endfunction

  function automatic lex_t fail(lex_t x, logic [3:0] code);
    x.err = code;
    x.st  = S_ERROR;
    return x;
  endfunction

  // Bit 0 true, bit 1 false, bit 2 null: which keywords have c at position pos.
  function automatic logic [2:0] word_hits(logic [2:0] pos, logic [7:0] c);
    logic [2:0] h;
    case (pos)
      3'd0:    h = {c == "n", c == "f", c == "t"};
      3'd1:    h = {c == "u", c == "a", c == "r"};
      3'd2:    h = {c == "l", c == "l", c == "u"};
      3'd3:    h = {c == "l", c == "s", c == "e"};
      3'd4:    h = {1'b0, c == "e", 1'b0};
      default: h = 3'b000;
    endcase
    return h;
  endfunction

  function automatic lex_t word_take(lex_t x, logic [7:0] c);
    x.wm = x.wm & word_hits(x.wl, c);
    if (x.wl != 3'd7) x.wl = x.wl + 3'd1;
    return put_text(x, c);
  endfunction

  // Returns {found, token}.
  function automatic logic [4:0] word_token(lex_t x);
    if (x.wm[0] && x.wl == 3'd4) return {1'b1, jbt_pkg::TK_TRUE};
    if (x.wm[1] && x.wl == 3'd5) return {1'b1, jbt_pkg::TK_FALSE};
    if (x.wm[2] && x.wl == 3'd4) return {1'b1, jbt_pkg::TK_NULL};
    return 5'd0;
  endfunction

  // Returns {valid, value}.
  function automatic logic [4:0] hex_value(logic [7:0] c);
    if (is_digit(c)) return {1'b1, c[3:0]};
    if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic lex_t hex_step(lex_t x, logic [7:0] c, state_e nxt);
    logic [4:0] h;
    h = hex_value(c);
    if (!h[4]) return fail(x, jbt_pkg::ERR_BAD_HEX);
    x.cp = {x.cp[11:0], h[3:0]};
    x.st = nxt;
    return x;
  endfunction

  function automatic lex_t emit_utf8(lex_t x);
    logic [15:0] cp;
    cp = x.cp;
    if (cp <= 16'h007f) begin
      x = put_text(x, cp[7:0]);
    end else if (cp <= 16'h07ff) begin
      x = put_text(x, {3'b110, cp[10:6]});
      x = put_text(x, {2'b10, cp[5:0]});
    end else if (cp >= 16'hd800 && cp <= 16'hdfff) begin
      // Surrogate halves produce no text.
      x = x;
    end else begin
      x = put_text(x, {4'b1110, cp[15:12]});
      x = put_text(x, {2'b10, cp[11:6]});
      x = put_text(x, {2'b10, cp[5:0]});
    end
    return x;
  endfunction

  function automatic lex_t begin_token(lex_t x, logic [7:0] c);
    x.st = S_READY;
    case (c)
      8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d: x = x;
      "/": x.st = S_SLASH;
      "{": x = put_done(put_text(x, c), jbt_pkg::TK_LBRACE);
      "}": x = put_done(put_text(x, c), jbt_pkg::TK_RBRACE);
      ":": x = put_done(put_text(x, c), jbt_pkg::TK_COLON);
      ",": x = put_done(put_text(x, c), jbt_pkg::TK_COMMA);
      "[": x = put_done(put_text(x, c), jbt_pkg::TK_LBRACK);
      "]": x = put_done(put_text(x, c), jbt_pkg::TK_RBRACK);
      8'h22: x.st = S_STRING;
      "-": begin
        x = put_text(x, c);
        x.st = S_NEG;
      end
      "0": begin
        x = put_text(x, c);
        x.st = S_ZERO;
      end
      default: begin
        if (is_digit(c)) begin
          x = put_text(x, c);
          x.st = S_INT;
        end else if (is_alpha(c)) begin
          x.wm = 3'b111;
          x.wl = 3'd0;
          x = word_take(x, c);
          x.st = S_WORD;
        end else begin
          x = fail(x, jbt_pkg::ERR_BAD_CHAR);
        end
      end
    endcase
    return x;
  endfunction

  function automatic lex_t take_byte(lex_t x, logic [7:0] c);
    logic [4:0] wt;
    case (x.st)
      S_STRING: begin
        if (c == 8'h5c) x.st = S_ESC;
        else if (c == 8'h22) x = put_done(x, jbt_pkg::TK_STRING);
        else x = put_text(x, c);
      end
      S_ESC: begin
        x.st = S_STRING;
        if (c == "u") begin
          x.cp = 16'd0;
          x.st = S_U1;
        end
        else if (c == "b") x = put_text(x, 8'h08);
        else if (c == "f") x = put_text(x, 8'h0c);
        else if (c == "n") x = put_text(x, 8'h0a);
        else if (c == "r") x = put_text(x, 8'h0d);
        else if (c == "t") x = put_text(x, 8'h09);
        else x = put_text(x, c);
      end
      S_U1: x = hex_step(x, c, S_U2);
      S_U2: x = hex_step(x, c, S_U3);
      S_U3: x = hex_step(x, c, S_U4);
      S_U4: begin
        x = hex_step(x, c, S_STRING);
        if (x.st == S_STRING) x = emit_utf8(x);
      end
      S_NEG: begin
        if (c == "0") begin
          x = put_text(x, c);
          x.st = S_ZERO;
        end else if (is_digit(c)) begin
          x = put_text(x, c);
          x.st = S_INT;
        end else begin
          x = fail(x, jbt_pkg::ERR_MINUS);
        end
      end
      S_ZERO, S_INT: begin
        if (c == ".") begin
          x = put_text(x, c);
          x.st = S_FRAC;
        end else if (c == "e" || c == "E") begin
          x = put_text(x, c);
          x.st = S_EXP;
        end else if (is_digit(c)) begin
          if (x.st == S_ZERO) x = fail(x, jbt_pkg::ERR_LEAD_ZERO);
          else x = put_text(x, c);
        end else begin
          x = begin_token(put_done(x, jbt_pkg::TK_INTEGER), c);
        end
      end
      S_FRAC: begin
        if (is_digit(c)) begin
          x = put_text(x, c);
          x.st = S_FRACMORE;
        end else begin
          x = fail(x, jbt_pkg::ERR_POINT);
        end
      end
      S_FRACMORE: begin
        if (is_digit(c)) begin
          x = put_text(x, c);
        end else if (c == "e" || c == "E") begin
          x = put_text(x, c);
          x.st = S_EXP;
        end else begin
          x = begin_token(put_done(x, jbt_pkg::TK_REAL), c);
        end
      end
      S_EXP: begin
        if (is_digit(c)) begin
          x = put_text(x, c);
          x.st = S_EXPMORE;
        end else if (c == "-" || c == "+") begin
          x = put_text(x, c);
          x.st = S_EXPSIGN;
        end else begin
          x = fail(x, jbt_pkg::ERR_EXPONENT);
        end
      end
      S_EXPSIGN: begin
        if (is_digit(c)) begin
          x = put_text(x, c);
          x.st = S_EXPMORE;
        end else begin
          x = fail(x, jbt_pkg::ERR_EXP_SIGN);
        end
      end
      S_EXPMORE: begin
        if (is_digit(c)) x = put_text(x, c);
        else x = begin_token(put_done(x, jbt_pkg::TK_REAL), c);
      end
      S_SLASH: begin
        if (c == "/") x.st = S_COMMENT;
        else x = fail(x, jbt_pkg::ERR_BAD_SLASH);
      end
      S_COMMENT: begin
        if (c == 8'h0a) x.st = S_READY;
      end
      S_WORD: begin
        if (is_alpha(c) || is_digit(c)) begin
          x = word_take(x, c);
        end else begin
          wt = word_token(x);
          if (!wt[4]) x = fail(x, jbt_pkg::ERR_BAREWORD);
          else x = begin_token(put_done(x, wt[3:0]), c);
        end
      end
      default: x = begin_token(x, c);
    endcase
    return x;
  endfunction

  function automatic lex_t take_end(lex_t x);
    logic [4:0] wt;
    case (x.st)
      S_READY:               x = x;
      S_ZERO, S_INT:         x = put_done(x, jbt_pkg::TK_INTEGER);
      S_FRACMORE, S_EXPMORE: x = put_done(x, jbt_pkg::TK_REAL);
      S_WORD: begin
        wt = word_token(x);
        if (!wt[4]) x = fail(x, jbt_pkg::ERR_BAREWORD);
        else x = put_done(x, wt[3:0]);
      end
      default: x = fail(x, jbt_pkg::ERR_END_IN_TOK);
    endcase
    return x;
  endfunction

  always_comb begin
    lx     = '0;
    lx.st  = state_q;
    lx.cp  = cp_q;
    lx.wm  = wm_q;
    lx.wl  = wl_q;
    lx.err = jbt_pkg::ERR_NONE;
    case (opcode_i)
      jbt_pkg::OP_RESTART: begin
        lx.st = S_READY;
        lx.cp = 16'd0;
        lx.wm = 3'd0;
        lx.wl = 3'd0;
      end
      jbt_pkg::OP_NONE: lx = lx;
      default: begin
        if (state_q == S_ERROR) lx.err = jbt_pkg::ERR_PRIOR;
        else if (opcode_i == jbt_pkg::OP_DATA) lx = take_byte(lx, data_byte_i);
        else lx = take_end(lx);
      end
    endcase
    // An item always yields at least one result; an error adds a closing empty one.
    if (lx.b.count == 2'd0 || lx.err != jbt_pkg::ERR_NONE) begin
      if (lx.b.count == 2'd3) lx.b.count = 2'd2;
      lx = push(lx, jbt_pkg::KIND_NONE, 8'd0, 4'd0);
    end
    lx.b.status     = (lx.st == S_ERROR);
    lx.b.error_code = lx.err;
  end

  assign bundle_o = lx.b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_READY;
      cp_q    <= 16'd0;
      wm_q    <= 3'd0;
      wl_q    <= 3'd0;
    end else if (accept_i) begin
      state_q <= lx.st;
      cp_q    <= lx.cp;
      wm_q    <= lx.wm;
      wl_q    <= lx.wl;
    end
  end

endmodule

/* rtl/jbt_out.sv */
// Result register: holds one item's bundle and hands out its results one per
// ready cycle, loading the next bundle as the last leaves. Depends on jbt_pkg.
module jbt_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  jbt_pkg::bundle_t  bundle_i,
  input  logic              res_ready_i,
  output logic              in_ready_o,
  output logic              res_valid_o,
  output jbt_pkg::result_t  res_o
);

  jbt_pkg::bundle_t bundle_q;
  logic [1:0]       idx_q;
  logic             valid_q;
  logic             last;
  jbt_pkg::slot_t   slot;

  assign slot = bundle_q.slots[idx_q];
  assign last = (idx_q == bundle_q.count - 2'd1);

  // A new item enters when nothing is held or the last result is being taken.
  assign in_ready_o  = !valid_q || (res_ready_i && last);
  assign res_valid_o = valid_q;

  assign res_o.kind       = slot.kind;
  assign res_o.text_byte  = slot.text_byte;
  assign res_o.token_kind = slot.token_kind;
  assign res_o.status     = bundle_q.status;
  assign res_o.error_code = bundle_q.error_code;
  assign res_o.last       = last;

  always_ff @(posedge clk_i) begin
    if (load_i) bundle_q <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= 2'd0;
    end else if (valid_q && res_ready_i) begin
      if (last) valid_q <= 1'b0;
      else idx_q <= idx_q + 2'd1;
    end
  end

endmodule

/* rtl/json_byte_tokenizer.sv */
// Top level of the JSON byte tokenizer. Depends on jbt_pkg, the channel
// interfaces, jbt_lexer and jbt_out.
//
// The tokenizer takes one item per cycle when not stalled (a data byte, end
// of stream or restart) and answers each with one to three result items. An
// item is lexed combinationally into the result register, and its first
// result is offered in the cycle after acceptance. The results leave one per
// cycle while the receiver is ready, and while it stays ready single-result
// items stream at one per clock. The next item is accepted in the same cycle
// the previous item's last result is taken. No initialization pass follows
// reset.
module json_byte_tokenizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  jbt_in_if.sink    in_i,
  jbt_out_if.source out_o
);

  logic             accept;
  logic             in_ready;
  jbt_pkg::bundle_t bundle;
  jbt_pkg::result_t res;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  jbt_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (in_i.opcode),
    .data_byte_i (in_i.data_byte),
    .bundle_o    (bundle)
  );

  jbt_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .bundle_i    (bundle),
    .res_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .res_valid_o (out_o.valid),
    .res_o       (res)
  );

  assign out_o.kind       = res.kind;
  assign out_o.text_byte  = res.text_byte;
  assign out_o.token_kind = res.token_kind;
  assign out_o.status     = res.status;
  assign out_o.error_code = res.error_code;
  assign out_o.last       = res.last;

endmodule

/* rtl/jbt_checker.sv */
// Port-level checks for the JSON byte tokenizer, bound to its top level.
// Depends on jbt_pkg and json_byte_tokenizer.
module jbt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_kind_i,
  input logic [7:0] out_text_byte_i,
  input logic [3:0] out_token_kind_i,
  input logic       out_status_i,
  input logic [3:0] out_error_code_i,
  input logic       out_last_i
);

  // A stalled result stays valid and keeps its kind, byte and last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
      $stable(out_text_byte_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // Any error report leaves the lexer in its error state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_error_code_i != jbt_pkg::ERR_NONE |-> out_status_i)
    else $error("error code without error status");

  // An empty result only ever closes an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == jbt_pkg::KIND_NONE |-> out_last_i)
    else $error("empty result not last");

  // Unused fields stay zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_kind_i == jbt_pkg::KIND_TEXT || out_text_byte_i == 8'd0) &&
      (out_kind_i == jbt_pkg::KIND_DONE || out_token_kind_i == 4'd0))
    else $error("stray payload field");

  // With no result pending the input is never stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output empty");

endmodule

bind json_byte_tokenizer jbt_checker u_jbt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_kind_i       (out_o.kind),
  .out_text_byte_i  (out_o.text_byte),
  .out_token_kind_i (out_o.token_kind),
  .out_status_i     (out_o.status),
  .out_error_code_i (out_o.error_code),
  .out_last_i       (out_o.last)
);

/* dv/json_byte_tokenizer_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for json_byte_tokenizer: directed rows, then random JSON fragments.
// Depends on jbt_pkg, the channel interfaces in jbt_if.sv and the tokenizer RTL.
module json_byte_tokenizer_tb;
  import jbt_pkg::*;

  typedef enum logic [4:0] {
    LX_READY, LX_STRING, LX_ESC, LX_U1, LX_U2, LX_U3, LX_U4, LX_NEG, LX_ZERO, LX_INT,
    LX_FRAC, LX_FRACMORE, LX_EXP, LX_EXPSIGN, LX_EXPMORE, LX_SLASH, LX_COMMENT, LX_WORD,
    LX_ERROR
  } lex_state_e;

  // How a stimulus row is checked: by the predictor, or against a typed single result.
  localparam logic [1:0] CHK_PRED  = 2'b00;
  localparam logic [1:0] CHK_QUIET = 2'b10;
  localparam logic [1:0] CHK_ERROR = 2'b11;

  localparam logic [3:0] TK_NO_WORD = 4'hF;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic       typed;
    logic       status;
    logic [3:0] code;
  } row_t;

  logic clk;
  logic rst_n;

  jbt_in_if  in_if ();
  jbt_out_if out_if ();

  json_byte_tokenizer u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Lexer shadow state.
  lex_state_e  lx_state;
  logic [15:0] lx_cp;
  logic [2:0]  lx_match;
  logic [2:0]  lx_len;

  // Results of the item being predicted.
  result_t     item_res [MAX_RESULTS];
  int          item_n;
  logic [3:0]  item_err;

  result_t     lex_results_q [$];
  row_t        stim_q [$];
  row_t        directed_rows [25];
  int          error_count = 0;
  int          result_count = 0;
  int          drive_phase = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_error(string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_error($sformatf("result %0d: %s is %0d, expected %0d", result_count, name, got,
                             want));
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void add_slot(logic [1:0] kind, logic [7:0] ch, logic [3:0] tok);
    if (item_n < MAX_RESULTS) begin
      item_res[item_n] = '0;
      item_res[item_n].kind = kind;
      item_res[item_n].text_byte = ch;
      item_res[item_n].token_kind = tok;
      item_n++;
    end
  endfunction

  function automatic void add_text(logic [7:0] ch);
    add_slot(KIND_TEXT, ch, '0);
  endfunction

  function automatic void add_done(logic [3:0] tok);
    add_slot(KIND_DONE, '0, tok);
    lx_state = LX_READY;
  endfunction

  function automatic void set_error(logic [3:0] code);
    item_err = code;
    lx_state = LX_ERROR;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (is_digit(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic string word_text(int w);
    case (w)
      0:       return "true";
      1:       return "false";
      default: return "null";
    endcase
  endfunction

  function automatic logic [3:0] word_kind(int w);
    case (w)
      0:       return TK_TRUE;
      1:       return TK_FALSE;
      default: return TK_NULL;
    endcase
  endfunction

  function automatic void word_take(logic [7:0] c);
    string wt;
    int    pos;
    pos = lx_len;
    for (int w = 0; w < 3; w++) begin
      wt = word_text(w);
      if (!(pos < wt.len() && wt[pos] == c)) lx_match[w] = 1'b0;
    end
    if (lx_len < 3'd7) lx_len++;
    add_text(c);
  endfunction

  function automatic logic [3:0] word_token();
    string wt;
    for (int w = 0; w < 3; w++) begin
      wt = word_text(w);
      if (lx_match[w] && lx_len == wt.len()) return word_kind(w);
    end
    return TK_NO_WORD;
  endfunction

  function automatic void put_utf8(logic [15:0] cp);
    if (cp <= 16'h007F) begin
      add_text(cp[7:0]);
    end else if (cp <= 16'h07FF) begin
      add_text({3'b110, cp[10:6]});
      add_text({2'b10, cp[5:0]});
    end else if (cp < 16'hD800 || cp > 16'hDFFF) begin
      add_text({4'b1110, cp[15:12]});
      add_text({2'b10, cp[11:6]});
      add_text({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void begin_token(logic [7:0] c);
    lx_state = LX_READY;
    case (c)
      " ", 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: ;
      "/":  lx_state = LX_SLASH;
      "{":  begin add_text(c); add_done(TK_LBRACE); end
      "}":  begin add_text(c); add_done(TK_RBRACE); end
      ":":  begin add_text(c); add_done(TK_COLON); end
      ",":  begin add_text(c); add_done(TK_COMMA); end
      "[":  begin add_text(c); add_done(TK_LBRACK); end
      "]":  begin add_text(c); add_done(TK_RBRACK); end
      "\"": lx_state = LX_STRING;
      "-":  begin add_text(c); lx_state = LX_NEG; end
      "0":  begin add_text(c); lx_state = LX_ZERO; end
      default: begin
        if (is_digit(c)) begin
          add_text(c);
          lx_state = LX_INT;
        end else if (is_alpha(c)) begin
          lx_match = 3'b111;
          lx_len = '0;
          word_take(c);
          lx_state = LX_WORD;
        end else begin
          set_error(ERR_BAD_CHAR);
        end
      end
    endcase
  endfunction

  function automatic void close_and_begin(logic [3:0] tok, logic [7:0] c);
    add_done(tok);
    begin_token(c);
  endfunction

  function automatic void hex_step(logic [7:0] c, lex_state_e next);
    int h;
    h = hex_val(c);
    if (h < 0) begin
      set_error(ERR_BAD_HEX);
    end else begin
      lx_cp = {lx_cp[11:0], h[3:0]};
      lx_state = next;
    end
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    logic [3:0] tok;
    case (lx_state)
      LX_STRING: begin
        if (c == "\\") lx_state = LX_ESC;
        else if (c == "\"") add_done(TK_STRING);
        else add_text(c);
      end
      LX_ESC: begin
        lx_state = LX_STRING;
        case (c)
          "u": begin lx_cp = '0; lx_state = LX_U1; end
          "b": add_text(8'h08);
          "f": add_text(8'h0C);
          "n": add_text(8'h0A);
          "r": add_text(8'h0D);
          "t": add_text(8'h09);
          default: add_text(c);
        endcase
      end
      LX_U1: hex_step(c, LX_U2);
      LX_U2: hex_step(c, LX_U3);
      LX_U3: hex_step(c, LX_U4);
      LX_U4: begin
        hex_step(c, LX_STRING);
        if (lx_state == LX_STRING) put_utf8(lx_cp);
      end
      LX_NEG: begin
        if (c == "0") begin add_text(c); lx_state = LX_ZERO; end
        else if (is_digit(c)) begin add_text(c); lx_state = LX_INT; end
        else set_error(ERR_MINUS);
      end
      LX_ZERO, LX_INT: begin
        if (c == ".") begin
          add_text(c);
          lx_state = LX_FRAC;
        end else if (c == "e" || c == "E") begin
          add_text(c);
          lx_state = LX_EXP;
        end else if (is_digit(c)) begin
          if (lx_state == LX_ZERO) set_error(ERR_LEAD_ZERO);
          else add_text(c);
        end else begin
          close_and_begin(TK_INTEGER, c);
        end
      end
      LX_FRAC: begin
        if (is_digit(c)) begin add_text(c); lx_state = LX_FRACMORE; end
        else set_error(ERR_POINT);
      end
      LX_FRACMORE: begin
        if (is_digit(c)) add_text(c);
        else if (c == "e" || c == "E") begin add_text(c); lx_state = LX_EXP; end
        else close_and_begin(TK_REAL, c);
      end
      LX_EXP: begin
        if (is_digit(c)) begin add_text(c); lx_state = LX_EXPMORE; end
        else if (c == "-" || c == "+") begin add_text(c); lx_state = LX_EXPSIGN; end
        else set_error(ERR_EXPONENT);
      end
      LX_EXPSIGN: begin
        if (is_digit(c)) begin add_text(c); lx_state = LX_EXPMORE; end
        else set_error(ERR_EXP_SIGN);
      end
      LX_EXPMORE: begin
        if (is_digit(c)) add_text(c);
        else close_and_begin(TK_REAL, c);
      end
      LX_SLASH: begin
        if (c == "/") lx_state = LX_COMMENT;
        else set_error(ERR_BAD_SLASH);
      end
      LX_COMMENT: begin
        if (c == 8'h0A) lx_state = LX_READY;
      end
      LX_WORD: begin
        if (is_alpha(c) || is_digit(c)) begin
          word_take(c);
        end else begin
          tok = word_token();
          if (tok == TK_NO_WORD) set_error(ERR_BAREWORD);
          else close_and_begin(tok, c);
        end
      end
      default: begin_token(c);
    endcase
  endfunction

  function automatic void lex_end();
    logic [3:0] tok;
    case (lx_state)
      LX_READY: ;
      LX_ZERO, LX_INT: add_done(TK_INTEGER);
      LX_FRACMORE, LX_EXPMORE: add_done(TK_REAL);
      LX_WORD: begin
        tok = word_token();
        if (tok == TK_NO_WORD) set_error(ERR_BAREWORD);
        else add_done(tok);
      end
      default: set_error(ERR_END_IN_TOK);
    endcase
  endfunction

  function automatic void clear_lexer();
    lx_state = LX_READY;
    lx_cp = '0;
    lx_match = '0;
    lx_len = '0;
  endfunction

  // Works out every result that one accepted item causes, into item_res[0 .. item_n-1].
  function automatic void lex_item(logic [1:0] op, logic [7:0] c);
    item_n = 0;
    item_err = ERR_NONE;
    if (op == OP_RESTART) clear_lexer();
    else if (op == OP_NONE) ;
    else if (lx_state == LX_ERROR) item_err = ERR_PRIOR;
    else if (op == OP_DATA) lex_byte(c);
    else lex_end();
    // A raised error, or an item with nothing to show, ends in a bare status result.
    if (item_n == 0 || item_err != ERR_NONE) begin
      if (item_n >= MAX_RESULTS) item_n = MAX_RESULTS - 1;
      add_slot(KIND_NONE, '0, '0);
    end
    for (int k = 0; k < item_n; k++) begin
      item_res[k].status = (lx_state == LX_ERROR);
      item_res[k].error_code = item_err;
      item_res[k].last = (k == item_n - 1);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus builders

  function automatic void push_row(logic [1:0] op, logic [7:0] ch);
    row_t r;
    r = '0;
    r.op = op;
    r.ch = ch;
    stim_q.insert(stim_q.size(), r);
  endfunction

  function automatic void push_chars(string s);
    for (int i = 0; i < s.len(); i++) push_row(OP_DATA, s[i]);
  endfunction

  function automatic logic [7:0] pick_char(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    logic [7:0] base;
    if (v < 4'd10) return "0" + v;
    base = $urandom_range(1) ? "A" : "a";
    return base + 8'(v) - 8'd10;
  endfunction

  // Numbers and words need a terminator; sometimes the stream simply ends instead.
  function automatic void push_terminator();
    if ($urandom_range(4) == 0) push_row(OP_END, 8'($urandom_range(255)));
    else push_row(OP_DATA, pick_char(" ,]}:\n\t"));
  endfunction

  function automatic void gen_string();
    int          pick;
    logic [7:0]  c;
    logic [15:0] cp;
    push_row(OP_DATA, "\"");
    repeat ($urandom_range(5)) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        do c = 8'($urandom_range(8'h7E, 8'h20)); while (c == "\"" || c == "\\");
        push_row(OP_DATA, c);
      end else if (pick < 70) begin
        push_row(OP_DATA, 8'($urandom_range(1) ? $urandom_range(8'hFF, 8'h80)
                                                : $urandom_range(8'h1F)));
      end else if (pick < 85) begin
        push_row(OP_DATA, "\\");
        if ($urandom_range(3) == 0) begin
          do c = 8'($urandom_range(8'h7E, 8'h21)); while (c == "u");
        end else begin
          c = pick_char("bfnrt\"\\/");
        end
        push_row(OP_DATA, c);
      end else begin
        push_chars("\\u");
        case ($urandom_range(3))
          0:       cp = 16'($urandom_range(16'h007F));
          1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
          2:       cp = 16'($urandom_range(16'hFFFF, 16'h0800));
          default: cp = 16'($urandom_range(16'hDFFF, 16'hD800));
        endcase
        for (int k = 3; k >= 0; k--) push_row(OP_DATA, hex_char(cp[k*4 +: 4]));
      end
    end
    push_row(OP_DATA, "\"");
  endfunction

  function automatic void gen_number();
    if ($urandom_range(2) == 0) push_row(OP_DATA, "-");
    if ($urandom_range(3) == 0) begin
      push_row(OP_DATA, "0");
    end else begin
      push_row(OP_DATA, 8'("1" + $urandom_range(8)));
      repeat ($urandom_range(3)) push_row(OP_DATA, rand_digit());
    end
    if ($urandom_range(2) == 0) begin
      push_row(OP_DATA, ".");
      repeat ($urandom_range(3, 1)) push_row(OP_DATA, rand_digit());
    end
    if ($urandom_range(3) == 0) begin
      push_row(OP_DATA, pick_char("eE"));
      if ($urandom_range(1)) push_row(OP_DATA, pick_char("+-"));
      repeat ($urandom_range(2, 1)) push_row(OP_DATA, rand_digit());
    end
    push_terminator();
  endfunction

  function automatic void gen_word();
    bit odd_word;
    odd_word = 1'b0;
    case ($urandom_range(4))
      0: push_chars("true");
      1: push_chars("false");
      2: push_chars("null");
      3: begin
        odd_word = 1'b1;
        case ($urandom_range(4))
          0:       push_chars("nul");
          1:       push_chars("fals");
          2:       push_chars("truer");
          3:       push_chars("Null");
          default: push_chars("n0ll");
        endcase
      end
      default: begin
        odd_word = 1'b1;
        push_row(OP_DATA, pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
        repeat ($urandom_range(4))
          push_row(OP_DATA, pick_char("abcdefghijklmnopqrstuvwxyzXYZ0123456789"));
      end
    endcase
    push_terminator();
    // Most odd words end in an error, so clear it before going on.
    if (odd_word) push_row(OP_RESTART, 8'($urandom_range(255)));
  endfunction

  function automatic void gen_blank();
    logic [7:0] c;
    if ($urandom_range(1)) begin
      push_row(OP_DATA, pick_char(" \t\n\r\f"));
      push_row(OP_DATA, 8'h0B);
    end else begin
      push_chars("//");
      repeat ($urandom_range(4)) begin
        do c = 8'($urandom_range(255)); while (c == 8'h0A);
        push_row(OP_DATA, c);
      end
      if ($urandom_range(5) == 0) push_row(OP_END, '0);
      else push_row(OP_DATA, 8'h0A);
    end
  endfunction

  // Malformed input, up to three items in the stuck error state, then a restart.
  function automatic void gen_broken();
    case ($urandom_range(9))
      0: push_chars("-x");
      1: push_chars("01");
      2: push_chars("1.x");
      3: push_chars("1ex");
      4: push_chars("1e+x");
      5: push_chars("/x");
      6: push_chars("\"\\uG");
      7: push_chars("tru ");
      8: push_row(OP_DATA, 8'($urandom_range(8'hFF, 8'h80)));
      default: begin
        push_chars("\"ab");
        push_row(OP_END, '0);
      end
    endcase
    repeat ($urandom_range(2)) push_row(OP_DATA, 8'($urandom_range(255)));
    if ($urandom_range(2) == 0) push_row(OP_END, '0);
    push_row(OP_RESTART, 8'($urandom_range(255)));
  endfunction

  function automatic void gen_fragment();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      push_row(OP_DATA, pick_char("{}[]:,"));
    end else if (pick < 33) begin
      gen_string();
    end else if (pick < 55) begin
      gen_number();
    end else if (pick < 70) begin
      gen_word();
    end else if (pick < 78) begin
      gen_blank();
    end else if (pick < 86) begin
      gen_broken();
    end else if (pick < 92) begin
      push_row(OP_END, 8'($urandom_range(255)));
    end else if (pick < 96) begin
      push_row(OP_RESTART, 8'($urandom_range(255)));
    end else begin
      push_row(2'($urandom_range(3)), 8'($urandom_range(255)));
      if ($urandom_range(1)) push_row(OP_RESTART, '0);
    end
  endfunction

  // ---------------------------------------------------------------- result checker

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind = out_if.kind;
      got.text_byte = out_if.text_byte;
      got.token_kind = out_if.token_kind;
      got.status = out_if.status;
      got.error_code = out_if.error_code;
      got.last = out_if.last;
      if (lex_results_q.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        want = lex_results_q.pop_front();
        check_field("kind", got.kind, want.kind);
        check_field("text_byte", got.text_byte, want.text_byte);
        check_field("token_kind", got.token_kind, want.token_kind);
        check_field("status", got.status, want.status);
        check_field("error_code", got.error_code, want.error_code);
        check_field("last", got.last, want.last);
      end
      result_count++;
    end
  end

  // ---------------------------------------------------------------- result receiver

  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    int  idle_pct;
    hold_left = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      // Once, hold off long enough that the block backs up into its input.
      if (drive_phase == 2 && !hold_done) begin
        hold_left = 80;
        hold_done = 1'b1;
      end
      idle_pct = (drive_phase == 0) ? 46 : (drive_phase == 1) ? 37 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    row_t    r;
    result_t quiet;
    int      n_directed;
    int      split1;
    int      split2;
    int      gap_pct;

    rst_n = 1'b0;
    in_if.valid <= 1'b0;
    in_if.opcode <= OP_DATA;
    in_if.data_byte <= '0;
    clear_lexer();

    directed_rows = '{
      {OP_END,     8'h00, CHK_QUIET, ERR_NONE},
      {OP_DATA,    "{",   CHK_PRED,  ERR_NONE},
      {OP_DATA,    "\"",  CHK_PRED,  ERR_NONE},
      {OP_DATA,    8'hFF, CHK_PRED,  ERR_NONE},
      {OP_DATA,    "\\",  CHK_PRED,  ERR_NONE},
      {OP_DATA,    "n",   CHK_PRED,  ERR_NONE},
      {OP_DATA,    "\\",  CHK_PRED,  ERR_NONE},
      {OP_DATA,    "u",   CHK_PRED,  ERR_NONE},
      {OP_DATA,    "F",   CHK_PRED,  ERR_NONE},
      {OP_DATA,    "f",   CHK_PRED,  ERR_NONE},
      {OP_DATA,    "F",   CHK_PRED,  ERR_NONE},
      {OP_DATA,    "f",   CHK_PRED,  ERR_NONE},
      {OP_DATA,    "\"",  CHK_PRED,  ERR_NONE},
      {OP_DATA,    "-",   CHK_PRED,  ERR_NONE},
      {OP_DATA,    "1",   CHK_PRED,  ERR_NONE},
      {OP_DATA,    "]",   CHK_PRED,  ERR_NONE},
      {OP_DATA,    "n",   CHK_PRED,  ERR_NONE},
      {OP_DATA,    "u",   CHK_PRED,  ERR_NONE},
      {OP_DATA,    "l",   CHK_PRED,  ERR_NONE},
      {OP_DATA,    "l",   CHK_PRED,  ERR_NONE},
      {OP_END,     8'h00, CHK_PRED,  ERR_NONE},
      {OP_NONE,    8'h5A, CHK_QUIET, ERR_NONE},
      {OP_DATA,    8'h00, CHK_ERROR, ERR_BAD_CHAR},
      {OP_DATA,    "0",   CHK_ERROR, ERR_PRIOR},
      {OP_RESTART, 8'hFF, CHK_QUIET, ERR_NONE}
    };
    foreach (directed_rows[i]) stim_q.insert(stim_q.size(), directed_rows[i]);
    n_directed = stim_q.size();
    while (stim_q.size() < n_directed + 185) gen_fragment();
    split1 = n_directed + (stim_q.size() - n_directed) / 3;
    split2 = n_directed + 2 * (stim_q.size() - n_directed) / 3;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < stim_q.size(); i++) begin
      r = stim_q[i];
      drive_phase = (i < split1) ? 0 : (i < split2) ? 1 : 2;
      gap_pct = (drive_phase == 0) ? 37 : (drive_phase == 1) ? 46 : 0;
      while ($urandom_range(99) < gap_pct) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
      in_if.valid <= 1'b1;
      in_if.opcode <= r.op;
      in_if.data_byte <= r.ch;
      do @(posedge clk); while (!in_if.ready);
      // The item was taken at this edge.
      lex_item(r.op, r.ch);
      if (r.typed) begin
        quiet = '0;
        quiet.kind = KIND_NONE;
        quiet.status = r.status;
        quiet.error_code = r.code;
        quiet.last = 1'b1;
        item_res[0] = quiet;
        item_n = 1;
      end
      for (int k = 0; k < item_n; k++) lex_results_q.insert(lex_results_q.size(), item_res[k]);
    end
    in_if.valid <= 1'b0;

    for (int i = 0; i < 2000 && lex_results_q.size() != 0; i++) @(posedge clk);
    if (lex_results_q.size() != 0)
      report_error($sformatf("%0d expected results never arrived", lex_results_q.size()));
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
